/* rtl/spbm_pkg.sv */
// Shared constants and types for the stereo peak-hold bar meter.
`timescale 1ns / 1ps

package spbm_pkg;

  // Fixed field widths.
  localparam int MAG_W  = 16;
  localparam int LVL_W  = 7;
  localparam int FAC_W  = 8;
  localparam int HOLD_W = 8;
  localparam int IDX_W  = 8;
  localparam int DATA_W = 8;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_NUM_LEVELS     = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_LOUD_THRESHOLD = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_DECAY_FACTOR   = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_HOLD_COUNT     = IDX_W'(3);

  // Register values after reset.
  localparam logic [LVL_W-1:0]  RST_NUM_LEVELS     = LVL_W'(30);
  localparam logic [LVL_W-1:0]  RST_LOUD_THRESHOLD = LVL_W'(24);
  localparam logic [FAC_W-1:0]  RST_DECAY_FACTOR   = FAC_W'(230);
  localparam logic [HOLD_W-1:0] RST_HOLD_COUNT     = HOLD_W'(30);

  // Bar and peak of one channel.
  typedef struct packed {
    logic [LVL_W-1:0] bar;
    logic [LVL_W-1:0] peak;
  } chan_state_t;

endpackage

/* rtl/spbm_sample_if.sv */
// Input channel carrying one stereo sample item.
`timescale 1ns / 1ps

interface spbm_sample_if;
  logic                        valid;
  logic                        ready;
  logic [spbm_pkg::MAG_W-1:0]  left_magnitude;
  logic [spbm_pkg::MAG_W-1:0]  right_magnitude;
  logic                        clear;

  modport source (output valid, output left_magnitude, output right_magnitude,
                  output clear, input ready);
  modport sink   (input valid, input left_magnitude, input right_magnitude,
                  input clear, output ready);
endinterface

/* rtl/spbm_result_if.sv */
// Output channel carrying one meter result item.
`timescale 1ns / 1ps

interface spbm_result_if;
  logic                        valid;
  logic                        ready;
  logic [spbm_pkg::LVL_W-1:0]  left_bar;
  logic [spbm_pkg::LVL_W-1:0]  right_bar;
  logic [spbm_pkg::LVL_W-1:0]  left_peak;
  logic [spbm_pkg::LVL_W-1:0]  right_peak;
  logic                        left_loud;
  logic                        right_loud;
  logic                        left_peak_loud;
  logic                        right_peak_loud;

  modport source (output valid, output left_bar, output right_bar, output left_peak,
                  output right_peak, output left_loud, output right_loud,
                  output left_peak_loud, output right_peak_loud, input ready);
  modport sink   (input valid, input left_bar, input right_bar, input left_peak,
                  input right_peak, input left_loud, input right_loud,
                  input left_peak_loud, input right_peak_loud, output ready);
endinterface

/* rtl/spbm_cfg_if.sv */
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps

interface spbm_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [spbm_pkg::IDX_W-1:0]   index;
  logic [spbm_pkg::DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/spbm_scale.sv */
// Magnitude to segment level quantiser for one lane.
`timescale 1ns / 1ps

module spbm_scale #(
  parameter int MAG_BITS   = 16,
  parameter int MAX_LEVELS = 64
) (
  input  logic [spbm_pkg::MAG_W-1:0] mag,
  input  logic [spbm_pkg::LVL_W-1:0] num_levels,
  output logic [spbm_pkg::LVL_W-1:0] level
);
  import spbm_pkg::*;

  localparam int PROD_W = MAG_W + LVL_W;
  localparam int MAXL_W = $clog2(MAX_LEVELS + 1) > LVL_W ? $clog2(MAX_LEVELS + 1) : LVL_W;
  localparam logic [MAXL_W-1:0] MAX_LV = MAXL_W'(MAX_LEVELS);
  localparam logic [MAG_W-1:0] MAG_MASK =
    (MAG_BITS >= MAG_W) ? {MAG_W{1'b1}} : MAG_W'((64'd1 << MAG_BITS) - 64'd1);

  logic [MAXL_W-1:0] lv_wide;
  logic [LVL_W-1:0]  lv;
  logic [MAG_W-1:0]  mag_used;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] scaled;

  // Full scale is limited to the largest supported number of levels.
  assign lv_wide = (MAXL_W'(num_levels) > MAX_LV) ? MAX_LV : MAXL_W'(num_levels);
  assign lv      = lv_wide[LVL_W-1:0];

  // Level is floor(mag * lv / 2^MAG_BITS), clamped to full scale.
  assign mag_used = mag & MAG_MASK;
  assign prod     = PROD_W'(mag_used) * PROD_W'(lv);
  assign scaled   = prod >> MAG_BITS;
  assign level    = (scaled > PROD_W'(lv)) ? lv : scaled[LVL_W-1:0];

endmodule

/* rtl/spbm_chan.sv */
// Bar, peak and hold counter update for one channel step.
`timescale 1ns / 1ps

module spbm_chan (
  input  logic [spbm_pkg::LVL_W-1:0]  level,
  input  spbm_pkg::chan_state_t       cur,
  input  logic [spbm_pkg::HOLD_W-1:0] hold_in,
  input  logic [spbm_pkg::HOLD_W-1:0] hold_count,
  input  logic [spbm_pkg::FAC_W-1:0]  decay_factor,
  output spbm_pkg::chan_state_t       nxt,
  output logic [spbm_pkg::HOLD_W-1:0] hold_out
);
  import spbm_pkg::*;

  localparam int DPROD_W = LVL_W + FAC_W;

  logic               rise;
  logic [LVL_W-1:0]   peak_held;
  logic [DPROD_W-1:0] decay_prod;

  // A new peak reloads the hold counter; otherwise it counts down to zero.
  assign rise      = level > cur.peak;
  assign peak_held = rise ? level : cur.peak;
  assign hold_out  = rise ? hold_count :
                     ((hold_in != '0) ? hold_in - HOLD_W'(1) : hold_in);

  // Once the hold has run out the peak drops one segment per step.
  assign nxt.peak = ((hold_out == '0) && (peak_held != '0)) ?
                    peak_held - LVL_W'(1) : peak_held;

  // The bar jumps up at once and falls by the decay factor.
  assign decay_prod = DPROD_W'(cur.bar) * DPROD_W'(decay_factor);

  always_comb begin
    if (level > cur.bar) begin
      nxt.bar = level;
    end else if (level < cur.bar) begin
      nxt.bar = decay_prod[DPROD_W-1:FAC_W];
    end else begin
      nxt.bar = cur.bar;
    end
  end

endmodule

/* rtl/stereo_peak_hold_bar_meter.sv */
// Top level of the stereo peak-hold bar meter.
`timescale 1ns / 1ps

// Stereo bar meter with a shared peak-hold counter.
// Channels: sample (left and right magnitude plus a clear flag) in, result
// (bar, peak and loud flags per side) out, and cfg, a write-only register
// port (index 0 num_levels, 1 loud_threshold, 2 decay_factor, 3 hold_count)
// that is always ready; unknown indexes are ignored.
// Each item passes two register stages: the first holds the quantised
// levels of both sides, computed by one lane each; the second applies the
// left and then the right channel step, chaining the hold counter through
// both lanes, and holds the result. A result is offered from the result
// register after its item has passed the level stage; one item per cycle is
// taken in steady state while result.ready stays high.
// Reset (rst, synchronous) clears bars, peaks, the hold counter and all
// valid flags, and loads the register defaults.
// When the receiver stalls, the result is held and an empty level stage
// takes one more item; after that sample.ready stays low until the
// result is taken.
module stereo_peak_hold_bar_meter #(
  parameter int MAX_LEVELS = 64,
  parameter int MAG_BITS   = 16
) (
  input logic           clk,
  input logic           rst,
  spbm_sample_if.sink   sample,
  spbm_result_if.source result,
  spbm_cfg_if.sink      cfg
);
  import spbm_pkg::*;

  localparam int LANES = 2;

  // Configuration registers.
  logic [LVL_W-1:0]  num_levels;
  logic [LVL_W-1:0]  loud_threshold;
  logic [FAC_W-1:0]  decay_factor;
  logic [HOLD_W-1:0] hold_count;

  // Level stage.
  logic                    lvl_valid;
  logic                    lvl_clear;
  logic [LVL_W-1:0]        lvl_level [LANES];
  logic [LVL_W-1:0]        level_next [LANES];
  logic [MAG_W-1:0]        lane_mag [LANES];

  // Meter state and channel step chain.
  chan_state_t             state [LANES];
  chan_state_t             state_step [LANES];
  logic [HOLD_W-1:0]       hold_counter;
  logic [HOLD_W-1:0]       hold_chain [LANES+1];

  logic advance;

  assign cfg.ready = 1'b1;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_levels     <= RST_NUM_LEVELS;
      loud_threshold <= RST_LOUD_THRESHOLD;
      decay_factor   <= RST_DECAY_FACTOR;
      hold_count     <= RST_HOLD_COUNT;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_NUM_LEVELS:     num_levels     <= cfg.data[LVL_W-1:0];
        REG_LOUD_THRESHOLD: loud_threshold <= cfg.data[LVL_W-1:0];
        REG_DECAY_FACTOR:   decay_factor   <= cfg.data[FAC_W-1:0];
        REG_HOLD_COUNT:     hold_count     <= cfg.data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage flow: the output register frees up when empty or taken.
  assign advance      = !result.valid || result.ready;
  assign sample.ready = !lvl_valid || advance;

  assign lane_mag[0]   = sample.left_magnitude;
  assign lane_mag[1]   = sample.right_magnitude;
  assign hold_chain[0] = hold_counter;

  // One quantiser and one channel step per side; the hold counter chains
  // from the left lane into the right.
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    spbm_scale #(
      .MAG_BITS   (MAG_BITS),
      .MAX_LEVELS (MAX_LEVELS)
    ) u_scale (
      .mag        (lane_mag[g]),
      .num_levels (num_levels),
      .level      (level_next[g])
    );

    spbm_chan u_chan (
      .level        (lvl_level[g]),
      .cur          (state[g]),
      .hold_in      (hold_chain[g]),
      .hold_count   (hold_count),
      .decay_factor (decay_factor),
      .nxt          (state_step[g]),
      .hold_out     (hold_chain[g+1])
    );
  end

  // Level stage registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      lvl_valid <= 1'b0;
    end else if (sample.ready) begin
      lvl_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.ready && sample.valid) begin
      lvl_clear <= sample.clear;
      for (int i = 0; i < LANES; i++) begin
        lvl_level[i] <= level_next[i];
      end
    end
  end

  // Meter state update; clear zeroes everything.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_counter <= '0;
      for (int i = 0; i < LANES; i++) begin
        state[i] <= '0;
      end
    end else if (advance && lvl_valid) begin
      if (lvl_clear) begin
        hold_counter <= '0;
        for (int i = 0; i < LANES; i++) begin
          state[i] <= '0;
        end
      end else begin
        hold_counter <= hold_chain[LANES];
        for (int i = 0; i < LANES; i++) begin
          state[i] <= state_step[i];
        end
      end
    end
  end

  // Result register, taken from the updated state.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= lvl_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && lvl_valid) begin
      if (lvl_clear) begin
        result.left_bar        <= '0;
        result.right_bar       <= '0;
        result.left_peak       <= '0;
        result.right_peak      <= '0;
        result.left_loud       <= (loud_threshold == '0);
        result.right_loud      <= (loud_threshold == '0);
        result.left_peak_loud  <= 1'b0;
        result.right_peak_loud <= 1'b0;
      end else begin
        result.left_bar        <= state_step[0].bar;
        result.right_bar       <= state_step[1].bar;
        result.left_peak       <= state_step[0].peak;
        result.right_peak      <= state_step[1].peak;
        result.left_loud       <= (state_step[0].bar >= loud_threshold);
        result.right_loud      <= (state_step[1].bar >= loud_threshold);
        result.left_peak_loud  <= (state_step[0].peak > loud_threshold);
        result.right_peak_loud <= (state_step[1].peak > loud_threshold);
      end
    end
  end

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the stereo peak-hold bar meter.
`timescale 1ns / 1ps

module testbench;
  import spbm_pkg::*;

  localparam int MAX_LEVELS     = 64;
  localparam int MAG_BITS       = 16;
  localparam int HALF_PERIOD    = 4;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASE_ITEMS    = 134;
  localparam int HOLD_OFF_LEN   = 80;
  localparam logic [IDX_W-1:0] REG_UNUSED = IDX_W'(200);

  // One stereo sample as it travels on the input channel.
  typedef struct packed {
    logic [MAG_W-1:0] left_magnitude;
    logic [MAG_W-1:0] right_magnitude;
    logic             clear;
  } stereo_sample_t;

  // One meter reading as it travels on the output channel.
  typedef struct packed {
    logic [LVL_W-1:0] left_bar;
    logic [LVL_W-1:0] right_bar;
    logic [LVL_W-1:0] left_peak;
    logic [LVL_W-1:0] right_peak;
    logic             left_loud;
    logic             right_loud;
    logic             left_peak_loud;
    logic             right_peak_loud;
  } meter_reading_t;

  logic clk;
  logic rst;

  spbm_sample_if sample_ch ();
  spbm_result_if result_ch ();
  spbm_cfg_if    cfg_ch ();

  stereo_peak_hold_bar_meter #(
    .MAX_LEVELS (MAX_LEVELS),
    .MAG_BITS   (MAG_BITS)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // Register copies and meter state of the predictor.
  logic [LVL_W-1:0]  cfg_levels = RST_NUM_LEVELS;
  logic [LVL_W-1:0]  cfg_red    = RST_LOUD_THRESHOLD;
  logic [FAC_W-1:0]  cfg_decay  = RST_DECAY_FACTOR;
  logic [HOLD_W-1:0] cfg_hold   = RST_HOLD_COUNT;
  logic [LVL_W-1:0]  bar_lvl [2];
  logic [LVL_W-1:0]  peak_lvl [2];
  logic [HOLD_W-1:0] hold_ctr;

  stereo_sample_t sample_backlog [$];
  meter_reading_t meter_readings [$];

  bit          sample_taken;
  bit          offering;
  bit          idle_on;
  int unsigned tx_gap;
  int unsigned rx_gap;
  int unsigned rx_hold;
  int unsigned envelope;
  int          failures;
  int          stall_cycles;

  // One channel step: quantise, update the shared hold counter and peak, move the bar.
  function automatic void meter_channel_step(input int ch, input logic [MAG_W-1:0] mag);
    longint unsigned full_scale;
    longint unsigned seg;
    longint unsigned fallen;
    full_scale = cfg_levels;
    if (full_scale > MAX_LEVELS) full_scale = MAX_LEVELS;
    seg = (longint'(mag) * full_scale) >> MAG_BITS;
    if (seg > full_scale) seg = full_scale;
    if (seg > peak_lvl[ch]) begin
      peak_lvl[ch] = LVL_W'(seg);
      hold_ctr = cfg_hold;
    end else if (hold_ctr > 0) begin
      hold_ctr = hold_ctr - 1'b1;
    end
    if (hold_ctr == 0 && peak_lvl[ch] > 0) peak_lvl[ch] = peak_lvl[ch] - 1'b1;
    if (seg > bar_lvl[ch]) begin
      bar_lvl[ch] = LVL_W'(seg);
    end else if (seg < bar_lvl[ch]) begin
      fallen = (longint'(bar_lvl[ch]) * longint'(cfg_decay)) >> 8;
      bar_lvl[ch] = LVL_W'(fallen);
    end
  endfunction

  // Apply one sample to the predicted state and return the reading it yields.
  function automatic meter_reading_t meter_update(input stereo_sample_t s);
    meter_reading_t r;
    if (s.clear) begin
      bar_lvl[0]  = '0;
      bar_lvl[1]  = '0;
      peak_lvl[0] = '0;
      peak_lvl[1] = '0;
      hold_ctr    = '0;
    end else begin
      meter_channel_step(0, s.left_magnitude);
      meter_channel_step(1, s.right_magnitude);
    end
    r.left_bar        = bar_lvl[0];
    r.right_bar       = bar_lvl[1];
    r.left_peak       = peak_lvl[0];
    r.right_peak      = peak_lvl[1];
    r.left_loud       = (bar_lvl[0] >= cfg_red);
    r.right_loud      = (bar_lvl[1] >= cfg_red);
    r.left_peak_loud  = (peak_lvl[0] > cfg_red);
    r.right_peak_loud = (peak_lvl[1] > cfg_red);
    return r;
  endfunction

  task automatic queue_sample(input logic [MAG_W-1:0] l, input logic [MAG_W-1:0] r,
                              input logic c);
    stereo_sample_t s;
    s.left_magnitude  = l;
    s.right_magnitude = r;
    s.clear           = c;
    sample_backlog.push_back(s);
  endtask

  // Mostly a slowly moving envelope with jitter, so that peaks are held and
  // decay; the rest is silence, full scale, noise and the odd clear.
  task automatic queue_random(input int count);
    int unsigned pick;
    int unsigned l;
    int unsigned r;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        queue_sample(MAG_W'($urandom), MAG_W'($urandom), 1'b1);
      end else if (pick < 16) begin
        queue_sample(MAG_W'($urandom), MAG_W'($urandom), 1'b0);
      end else if (pick < 24) begin
        queue_sample('0, '0, 1'b0);
      end else if (pick < 30) begin
        queue_sample('1, MAG_W'($urandom), 1'b0);
      end else begin
        if ($urandom_range(0, 15) == 0) envelope = $urandom_range(0, 65535);
        else envelope = envelope - envelope / 16;
        l = envelope - ((envelope < 2048) ? envelope / 2 : $urandom_range(0, 2047));
        r = envelope - ((envelope < 2048) ? envelope / 4 : $urandom_range(0, 2047));
        queue_sample(MAG_W'(l), MAG_W'(r), 1'b0);
      end
    end
  endtask

  // Write one register and mirror it in the predictor once accepted.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_NUM_LEVELS:     cfg_levels = val[LVL_W-1:0];
      REG_LOUD_THRESHOLD: cfg_red    = val[LVL_W-1:0];
      REG_DECAY_FACTOR:   cfg_decay  = val[FAC_W-1:0];
      REG_HOLD_COUNT:     cfg_hold   = val[HOLD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [DATA_W-1:0] levels, input logic [DATA_W-1:0] red,
                            input logic [DATA_W-1:0] decay, input logic [DATA_W-1:0] hold);
    write_reg(REG_NUM_LEVELS, levels);
    write_reg(REG_LOUD_THRESHOLD, red);
    write_reg(REG_DECAY_FACTOR, decay);
    write_reg(REG_HOLD_COUNT, hold);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Wait until every sample is taken and every reading has come back.
  task automatic wait_drained;
    while (sample_backlog.size() != 0 || meter_readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Clock.
  always #HALF_PERIOD clk = ~clk;

  // Predict each sample at the edge where it is taken.
  always @(posedge clk) begin
    if (!rst && sample_ch.valid && sample_ch.ready) begin
      meter_readings.push_back(meter_update('{sample_ch.left_magnitude,
                                              sample_ch.right_magnitude,
                                              sample_ch.clear}));
      sample_taken = 1'b1;
    end
  end

  // Sample driver: an offered item is held until taken; gaps only fall between items.
  always @(negedge clk) begin
    if (sample_taken) begin
      void'(sample_backlog.pop_front());
      sample_taken = 1'b0;
      offering     = 1'b0;
    end
    if (!offering && idle_on && tx_gap == 0 && sample_backlog.size() != 0 &&
        $urandom_range(0, 11) == 0) begin
      tx_gap = $urandom_range(1, 11);
    end
    if (!offering && tx_gap > 0) begin
      tx_gap = tx_gap - 1;
      sample_ch.valid <= 1'b0;
    end else if (sample_backlog.size() != 0) begin
      sample_ch.valid           <= 1'b1;
      sample_ch.left_magnitude  <= sample_backlog[0].left_magnitude;
      sample_ch.right_magnitude <= sample_backlog[0].right_magnitude;
      sample_ch.clear           <= sample_backlog[0].clear;
      offering = 1'b1;
    end else begin
      sample_ch.valid <= 1'b0;
    end
  end

  // Result receiver: a requested long hold-off first, then random stall bursts.
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold = rx_hold - 1;
      result_ch.ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap = rx_gap - 1;
      result_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 11) == 0) begin
      rx_gap = $urandom_range(1, 11) - 1;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  // Compare each reading with the oldest prediction, field by field.
  always @(posedge clk) begin
    meter_reading_t got;
    meter_reading_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got = '{result_ch.left_bar, result_ch.right_bar, result_ch.left_peak,
              result_ch.right_peak, result_ch.left_loud, result_ch.right_loud,
              result_ch.left_peak_loud, result_ch.right_peak_loud};
      if (meter_readings.size() == 0) begin
        failures++;
        if (failures <= 10) $display("%0t: reading with none predicted: %p", $realtime, got);
      end else begin
        want = meter_readings.pop_front();
        if (got.left_bar !== want.left_bar || got.right_bar !== want.right_bar ||
            got.left_peak !== want.left_peak || got.right_peak !== want.right_peak ||
            got.left_loud !== want.left_loud || got.right_loud !== want.right_loud ||
            got.left_peak_loud !== want.left_peak_loud ||
            got.right_peak_loud !== want.right_peak_loud) begin
          failures++;
          if (failures <= 10) begin
            $display("%0t: reading mismatch", $realtime);
            $display("  expected %p", want);
            $display("  actual   %p", got);
          end
        end
      end
    end
  end

  // Watchdog on cycles in which no channel moves an item.
  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Reset, directed samples, then configuration phases with random samples.
  initial begin
    clk                       = 1'b0;
    rst                       = 1'b1;
    sample_ch.valid           = 1'b0;
    sample_ch.left_magnitude  = '0;
    sample_ch.right_magnitude = '0;
    sample_ch.clear           = 1'b0;
    result_ch.ready           = 1'b0;
    cfg_ch.valid              = 1'b0;
    cfg_ch.index              = '0;
    cfg_ch.data               = '0;
    bar_lvl[0]                = '0;
    bar_lvl[1]                = '0;
    peak_lvl[0]               = '0;
    peak_lvl[1]               = '0;
    hold_ctr                  = '0;
    idle_on                   = 1'b1;
    envelope                  = 0;
    failures                  = 0;
    stall_cycles              = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed samples under the reset settings: clear with levels, full scale,
    // silence, one-sided input, alternating bits and a segment boundary.
    queue_sample('1, '1, 1'b1);
    queue_sample('1, '1, 1'b0);
    queue_sample('0, '0, 1'b0);
    queue_sample('1, '0, 1'b0);
    queue_sample('0, '1, 1'b0);
    queue_sample(16'h5555, 16'hAAAA, 1'b0);
    queue_sample(16'hAAAA, 16'h5555, 1'b0);
    queue_sample(16'h8000, 16'h4000, 1'b0);
    queue_sample(16'h0001, 16'hFFFE, 1'b0);
    queue_sample(16'h0889, 16'h0888, 1'b0);
    queue_sample(16'h1234, 16'h5678, 1'b1);
    queue_sample('0, '0, 1'b0);
    wait_drained();

    for (int p = 0; p < 10; p++) begin
      case (p)
        // Widest scale, everything loud, slowest bar fall, longest hold.
        0: set_config(8'd64, 8'd0, 8'd255, 8'd255);
        // Scale shrinks below the held bars; bars drop to zero; peaks never held.
        1: set_config(8'd4, 8'd64, 8'd0, 8'd0);
        // Scale above the maximum; loud never reached; shortest hold.
        2: set_config(8'd127, 8'd127, 8'd128, 8'd1);
        // No levels at all; an unknown register index is ignored.
        3: begin
          write_reg(REG_UNUSED, 8'hFF);
          set_config(8'd0, 8'd0, 8'd200, 8'd10);
        end
        4: set_config(8'd1, 8'd1, 8'd255, 8'd3);
        default: set_config(DATA_W'($urandom_range(0, 255)), DATA_W'($urandom_range(0, 255)),
                            DATA_W'($urandom_range(0, 255)), DATA_W'($urandom_range(0, 255)));
      endcase
      idle_on = (p != 6 && p != 9);
      if (p == 4) begin
        // The sender pauses halfway until every reading is back.
        queue_random(PHASE_ITEMS / 2);
        wait_drained();
        queue_random(PHASE_ITEMS - PHASE_ITEMS / 2);
      end else begin
        queue_random(PHASE_ITEMS);
      end
      if (p == 0) begin
        queue_sample('1, '1, 1'b0);
        queue_sample('1, '1, 1'b0);
      end
      if (p == 2) begin
        // Long receiver hold-off while samples keep coming, to fill the block.
        while (sample_backlog.size() > PHASE_ITEMS - 30) @(posedge clk);
        rx_hold = HOLD_OFF_LEN;
      end
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (failures == 0 && meter_readings.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/spbm_pkg.sv
rtl/spbm_sample_if.sv
rtl/spbm_result_if.sv
rtl/spbm_cfg_if.sv
rtl/spbm_scale.sv
rtl/spbm_chan.sv
rtl/stereo_peak_hold_bar_meter.sv
sim/testbench.sv
